[design/command_line_tokenizer_top_macros.svh]
`ifndef COMMAND_LINE_TOKENIZER_TOP_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that the consequent holds in every cycle in which the antecedent holds.
`define CLT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the expression is never true.
`define CLT_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`else

`define CLT_ASSERT_IMPL(lbl, ante, cons, msg)
`define CLT_ASSERT_NEVER(lbl, expr, msg)

`endif

`endif

[design/clt_pkg.sv]
`timescale 1ns / 1ps

package clt_pkg;

	localparam int LINE_BITS = 16;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	typedef enum logic [2:0] {
		EV_APPEND       = 3'd0,
		EV_BEGIN_CMD    = 3'd1,
		EV_BEGIN_IDENT  = 3'd2,
		EV_BEGIN_STRING = 3'd3,
		EV_EXECUTE      = 3'd4,
		EV_END          = 3'd5,
		EV_ERROR        = 3'd6
	} evkind_t;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_UNEXPECTED = 2'd1,
		ERR_ESCAPE     = 2'd2,
		ERR_NEWLINE    = 2'd3
	} errcode_t;

	typedef struct packed {
		evkind_t               kind;
		logic [7:0]            ch;
		errcode_t              code;
		logic [LINE_BITS-1:0]  line;
		logic                  last;
	} event_t;

	// Up to two events produced by one text byte, in order.
	typedef struct packed {
		logic [1:0] n;
		event_t     ev0;
		event_t     ev1;
	} push_t;

	function automatic logic is_space(logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_CR) || (c == CH_TAB);
	endfunction

	function automatic logic is_delim(logic [7:0] c);
		return (c == CH_SEMI) || (c == CH_LF);
	endfunction

	function automatic logic is_ident(logic [7:0] c);
		logic r;
		r = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
			((c >= 8'h30) && (c <= 8'h39));
		case (c)
			8'h2B, 8'h2D, 8'h2E, 8'h3A, 8'h5F, 8'h5E, 8'h24: r = 1'b1;
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic is_strchar(logic [7:0] c);
		logic r;
		r = is_ident(c);
		case (c)
			8'h20, 8'h09, 8'h60, 8'h7E, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
			8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h2D, 8'h3D, 8'h5C, 8'h7C,
			8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3B, 8'h27, 8'h3A, 8'h3C, 8'h3E, 8'h2C,
			8'h2E, 8'h2F, 8'h3F: r = 1'b1;
			default: ;
		endcase
		return r;
	endfunction

endpackage

[design/clt_if.sv]
`timescale 1ns / 1ps

interface clt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source (output valid, output text_byte, input ready);
	modport sink (input valid, input text_byte, output ready);
endinterface

interface clt_event_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    event_kind;
	logic [7:0]                    event_char;
	logic [1:0]                    error_code;
	logic [clt_pkg::LINE_BITS-1:0] error_line;
	logic                          last;

	modport source (output valid, output event_kind, output event_char, output error_code,
		output error_line, output last, input ready);
	modport sink (input valid, input event_kind, input event_char, input error_code,
		input error_line, input last, output ready);
endinterface

[design/clt_front.sv]
`timescale 1ns / 1ps

module clt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  logic [7:0]      text_byte,
	output clt_pkg::push_t  push
);

	typedef enum logic [2:0] {
		ST_BEGIN_CMD = 3'd0,
		ST_CMD_NAME  = 3'd1,
		ST_BEGIN_ARG = 3'd2,
		ST_STRING    = 3'd3,
		ST_IDENT     = 3'd4,
		ST_ESCAPE    = 3'd5,
		ST_ERROR     = 3'd6
	} pstate_t;

	typedef struct packed {
		pstate_t          st;
		logic             emit;
		clt_pkg::event_t  ev;
		logic             rearm;
	} tok_t;

	function automatic tok_t tok(pstate_t st, logic [7:0] c,
			logic [clt_pkg::LINE_BITS-1:0] line);
		tok_t              r;
		logic              f;
		clt_pkg::errcode_t fc;
		r = '0;
		r.st = st;
		r.ev.kind = clt_pkg::EV_APPEND;
		r.ev.code = clt_pkg::ERR_NONE;
		f = 1'b0;
		fc = clt_pkg::ERR_UNEXPECTED;
		case (st)
			ST_BEGIN_CMD: begin
				if (clt_pkg::is_space(c) || clt_pkg::is_delim(c)) begin
				end else if (c == clt_pkg::CH_NUL) begin
					r.emit = 1'b1;
					r.ev.kind = clt_pkg::EV_END;
					r.rearm = 1'b1;
				end else if (clt_pkg::is_ident(c)) begin
					r.emit = 1'b1;
					r.ev.kind = clt_pkg::EV_BEGIN_CMD;
					r.ev.ch = c;
					r.st = ST_CMD_NAME;
				end else begin
					f = 1'b1;
				end
			end
			ST_CMD_NAME: begin
				if (clt_pkg::is_ident(c)) begin
					r.emit = 1'b1;
					r.ev.ch = c;
				end else if (clt_pkg::is_delim(c)) begin
					r.emit = 1'b1;
					r.ev.kind = clt_pkg::EV_EXECUTE;
					r.st = ST_BEGIN_CMD;
				end else if (clt_pkg::is_space(c)) begin
					r.st = ST_BEGIN_ARG;
				end else begin
					f = 1'b1;
				end
			end
			ST_BEGIN_ARG: begin
				if (clt_pkg::is_space(c)) begin
				end else if (clt_pkg::is_ident(c)) begin
					r.emit = 1'b1;
					r.ev.kind = clt_pkg::EV_BEGIN_IDENT;
					r.ev.ch = c;
					r.st = ST_IDENT;
				end else if (c == clt_pkg::CH_QUOTE) begin
					r.emit = 1'b1;
					r.ev.kind = clt_pkg::EV_BEGIN_STRING;
					r.st = ST_STRING;
				end else if (clt_pkg::is_delim(c)) begin
					r.emit = 1'b1;
					r.ev.kind = clt_pkg::EV_EXECUTE;
					r.st = ST_BEGIN_CMD;
				end else begin
					f = 1'b1;
				end
			end
			ST_STRING: begin
				if (c == clt_pkg::CH_BSLASH) begin
					r.st = ST_ESCAPE;
				end else if (c == clt_pkg::CH_QUOTE) begin
					r.st = ST_BEGIN_ARG;
				end else if (clt_pkg::is_strchar(c)) begin
					r.emit = 1'b1;
					r.ev.ch = c;
				end else begin
					f = 1'b1;
					if ((c == clt_pkg::CH_CR) || (c == clt_pkg::CH_LF)) begin
						fc = clt_pkg::ERR_NEWLINE;
					end
				end
			end
			ST_IDENT: begin
				if (clt_pkg::is_ident(c)) begin
					r.emit = 1'b1;
					r.ev.ch = c;
				end else if (clt_pkg::is_space(c)) begin
					r.st = ST_BEGIN_ARG;
				end else if (clt_pkg::is_delim(c)) begin
					r.emit = 1'b1;
					r.ev.kind = clt_pkg::EV_EXECUTE;
					r.st = ST_BEGIN_CMD;
				end else begin
					f = 1'b1;
				end
			end
			ST_ESCAPE: begin
				if ((c == clt_pkg::CH_QUOTE) || (c == clt_pkg::CH_BSLASH)) begin
					r.emit = 1'b1;
					r.ev.ch = c;
					r.st = ST_STRING;
				end else begin
					f = 1'b1;
					fc = clt_pkg::ERR_ESCAPE;
				end
			end
			default: begin
				r.rearm = (c == clt_pkg::CH_NUL);
			end
		endcase
		if (f) begin
			r.emit = 1'b1;
			r.ev.kind = clt_pkg::EV_ERROR;
			r.ev.code = fc;
			r.ev.line = line;
			r.st = ST_ERROR;
			r.rearm = (c == clt_pkg::CH_NUL);
		end
		return r;
	endfunction

	pstate_t                       pst_q, pst_d, mid_st;
	logic                          quotes_q, quotes_d, quotes_tog;
	logic                          comment_q, comment_d;
	logic                          slash_q, slash_d;
	logic [clt_pkg::LINE_BITS-1:0] line_q, line_d;
	tok_t                          t1, t2;
	logic                          e1, e2, nl, rearm;
	clt_pkg::event_t               ev_a, ev_b;

	always_comb begin
		t1 = tok(pst_q, clt_pkg::CH_SLASH, line_q);
		mid_st = slash_q ? t1.st : pst_q;
		t2 = tok(mid_st, text_byte, line_q);
		quotes_tog = quotes_q ^ (text_byte == clt_pkg::CH_QUOTE);
		nl = (text_byte == clt_pkg::CH_LF);
		pst_d = pst_q;
		quotes_d = quotes_q;
		comment_d = comment_q;
		slash_d = slash_q;
		line_d = line_q;
		e1 = 1'b0;
		e2 = 1'b0;
		rearm = 1'b0;
		if (pst_q == ST_ERROR) begin
			rearm = (text_byte == clt_pkg::CH_NUL);
		end else if (slash_q && (text_byte == clt_pkg::CH_SLASH)) begin
			slash_d = 1'b0;
			comment_d = 1'b1;
		end else begin
			e1 = slash_q & t1.emit;
			slash_d = 1'b0;
			pst_d = mid_st;
			if (text_byte == clt_pkg::CH_NUL) begin
				e2 = t2.emit;
				pst_d = t2.st;
				rearm = t2.rearm;
			end else begin
				quotes_d = quotes_tog;
				if (!quotes_tog && !comment_q && (text_byte == clt_pkg::CH_SLASH)) begin
					slash_d = 1'b1;
				end else begin
					if (nl) begin
						quotes_d = 1'b0;
						comment_d = 1'b0;
					end
					if (!comment_q || nl) begin
						e2 = t2.emit;
						pst_d = t2.st;
					end
					if (nl && (line_q != '1)) begin
						line_d = line_q + clt_pkg::LINE_BITS'(1);
					end
				end
			end
		end
		if (rearm) begin
			pst_d = ST_BEGIN_CMD;
			quotes_d = 1'b0;
			comment_d = 1'b0;
			slash_d = 1'b0;
			line_d = clt_pkg::LINE_BITS'(1);
		end
	end

	always_comb begin
		ev_a = t1.ev;
		ev_b = t2.ev;
		ev_a.last = 1'b1;
		ev_b.last = 1'b1;
		push.n = adv ? {e1 & e2, e1 ^ e2} : 2'd0;
		push.ev0 = e1 ? ev_a : ev_b;
		push.ev0.last = !(e1 && e2);
		push.ev1 = ev_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pst_q <= ST_BEGIN_CMD;
			quotes_q <= 1'b0;
			comment_q <= 1'b0;
			slash_q <= 1'b0;
			line_q <= clt_pkg::LINE_BITS'(1);
		end else if (adv) begin
			pst_q <= pst_d;
			quotes_q <= quotes_d;
			comment_q <= comment_d;
			slash_q <= slash_d;
			line_q <= line_d;
		end
	end

endmodule

[design/clt_outq.sv]
`timescale 1ns / 1ps

module clt_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  clt_pkg::push_t  push,
	output logic            room,
	clt_event_if.source     events
);

	clt_pkg::event_t                mem_q [clt_pkg::QDEPTH];
	logic [clt_pkg::QPTR_W-1:0]     wp_q, rp_q;
	logic [clt_pkg::QCNT_W-1:0]     cnt_q;
	logic                           pop;
	clt_pkg::event_t                head;

	assign head = mem_q[rp_q];
	assign pop = events.valid && events.ready;
	assign room = (cnt_q <= clt_pkg::QCNT_W'(clt_pkg::QDEPTH - 2));

	assign events.valid = (cnt_q != '0);
	assign events.event_kind = head.kind;
	assign events.event_char = head.ch;
	assign events.error_code = head.code;
	assign events.error_line = head.line;
	assign events.last = head.last;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wp_q] <= push.ev0;
		end
		if (push.n == 2'd2) begin
			mem_q[wp_q + clt_pkg::QPTR_W'(1)] <= push.ev1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + clt_pkg::QPTR_W'(push.n);
			rp_q <= rp_q + clt_pkg::QPTR_W'(pop);
			cnt_q <= cnt_q + clt_pkg::QCNT_W'(push.n) - clt_pkg::QCNT_W'(pop);
		end
	end

endmodule

[design/command_line_tokenizer_top.sv]
// A byte accepted on the input is registered in byte_s1; its events are then written
// into the event queue, from which the port presents them in order.
// Throughput: one byte per cycle, limited only by the four-entry event queue
// and by bytes that release a held slash and so produce two events.
// Reset: arst_n clears the tokenizer state, the line counter to one, and the queue.
`timescale 1ns / 1ps
`include "command_line_tokenizer_top_macros.svh"

module command_line_tokenizer_top (
	input  logic        clk,
	input  logic        arst_n,
	clt_byte_if.sink    text,
	clt_event_if.source events
);

	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            room;
	logic            adv;
	clt_pkg::push_t  push;

	assign adv = valid_s1 && room;
	assign text.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.text_byte;
		end
	end

	clt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.text_byte (byte_s1),
		.push      (push)
	);

	clt_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.events (events)
	);

	`CLT_ASSERT_IMPL(a_no_push_without_request, !adv, push.n == 2'd0, "event pushed with no request")
	`CLT_ASSERT_NEVER(a_push_count, push.n == 2'd3, "more than two events from one request")
	`CLT_ASSERT_IMPL(a_end_error_last, events.valid && (events.event_kind == clt_pkg::EV_END || events.event_kind == clt_pkg::EV_ERROR), events.last, "end or error event not marked last")
	`CLT_ASSERT_IMPL(a_error_fields, events.valid && events.event_kind != clt_pkg::EV_ERROR, events.error_code == clt_pkg::ERR_NONE && events.error_line == '0, "error fields set on a non-error event")

endmodule

[tb/command_line_tokenizer_top_tb.sv]
`timescale 1ns / 1ps

module command_line_tokenizer_top_tb;

	typedef enum logic [2:0] {
		PS_BEGIN_CMD,
		PS_CMD_NAME,
		PS_BEGIN_ARG,
		PS_STRING,
		PS_IDENT,
		PS_ESCAPE,
		PS_DROP
	} tok_state_t;

	typedef struct packed {
		logic [7:0]       b;
		logic             has_event;
		clt_pkg::event_t  ev;
	} row_t;

	localparam string IDENT_SET =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789+-.:_^$";
	localparam string IDENT_PUNCT = "+-.:_^$";
	localparam string TEXT_PUNCT = " \t`~!@#$%^&*()_+-=\\|[]{};':<>,./?";
	localparam string BODY_SET =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789+-.:_^$ \t`~!@#%&*()=|[]{};':<>,./?";
	localparam int RANDOM_BYTES = 1250;

	logic clk;
	logic arst_n;

	clt_byte_if  text_bus ();
	clt_event_if ev_bus ();

	command_line_tokenizer_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_bus),
		.events (ev_bus)
	);

	tok_state_t                    tok_state;
	logic                          quoted;
	logic                          in_comment;
	logic                          slash_held;
	logic [clt_pkg::LINE_BITS-1:0] line_cnt;

	clt_pkg::event_t step_events[$];
	clt_pkg::event_t expected_events[$];
	logic [7:0]      text_q[$];
	int              events_seen;
	int              mismatches;
	bit              tx_quiet;
	row_t            dir_rows[28];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("command_line_tokenizer_top regression: fail");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic in_set(logic [7:0] c, string s);
		for (int i = 0; i < s.len(); i++) begin
			if (s[i] == c) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic logic blank_ch(logic [7:0] c);
		return c == clt_pkg::CH_SPACE || c == clt_pkg::CH_CR || c == clt_pkg::CH_TAB;
	endfunction

	function automatic logic delim_ch(logic [7:0] c);
		return c == clt_pkg::CH_SEMI || c == clt_pkg::CH_LF;
	endfunction

	function automatic logic ident_ch(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9") ||
			in_set(c, IDENT_PUNCT);
	endfunction

	function automatic logic text_ch(logic [7:0] c);
		return ident_ch(c) || in_set(c, TEXT_PUNCT);
	endfunction

	function automatic void rearm();
		tok_state  = PS_BEGIN_CMD;
		quoted     = 1'b0;
		in_comment = 1'b0;
		slash_held = 1'b0;
		line_cnt   = clt_pkg::LINE_BITS'(1);
	endfunction

	function automatic void add_event(clt_pkg::evkind_t k, logic [7:0] ch,
		clt_pkg::errcode_t code, logic [clt_pkg::LINE_BITS-1:0] ln);
		clt_pkg::event_t e;
		e.kind = k;
		e.ch   = ch;
		e.code = code;
		e.line = ln;
		e.last = 1'b0;
		step_events = {step_events, e};
	endfunction

	function automatic void raise_error(clt_pkg::errcode_t code, logic [7:0] c);
		add_event(clt_pkg::EV_ERROR, 8'h00, code, line_cnt);
		tok_state = PS_DROP;
		if (c == clt_pkg::CH_NUL) begin
			rearm();
		end
	endfunction

	function automatic void tokenize_char(logic [7:0] c);
		case (tok_state)
			PS_BEGIN_CMD: begin
				if (blank_ch(c) || delim_ch(c)) begin
				end else if (c == clt_pkg::CH_NUL) begin
					add_event(clt_pkg::EV_END, 8'h00, clt_pkg::ERR_NONE, '0);
					rearm();
				end else if (ident_ch(c)) begin
					add_event(clt_pkg::EV_BEGIN_CMD, c, clt_pkg::ERR_NONE, '0);
					tok_state = PS_CMD_NAME;
				end else begin
					raise_error(clt_pkg::ERR_UNEXPECTED, c);
				end
			end
			PS_CMD_NAME: begin
				if (ident_ch(c)) begin
					add_event(clt_pkg::EV_APPEND, c, clt_pkg::ERR_NONE, '0);
				end else if (delim_ch(c)) begin
					add_event(clt_pkg::EV_EXECUTE, 8'h00, clt_pkg::ERR_NONE, '0);
					tok_state = PS_BEGIN_CMD;
				end else if (blank_ch(c)) begin
					tok_state = PS_BEGIN_ARG;
				end else begin
					raise_error(clt_pkg::ERR_UNEXPECTED, c);
				end
			end
			PS_BEGIN_ARG: begin
				if (blank_ch(c)) begin
				end else if (ident_ch(c)) begin
					add_event(clt_pkg::EV_BEGIN_IDENT, c, clt_pkg::ERR_NONE, '0);
					tok_state = PS_IDENT;
				end else if (c == clt_pkg::CH_QUOTE) begin
					add_event(clt_pkg::EV_BEGIN_STRING, 8'h00, clt_pkg::ERR_NONE, '0);
					tok_state = PS_STRING;
				end else if (delim_ch(c)) begin
					add_event(clt_pkg::EV_EXECUTE, 8'h00, clt_pkg::ERR_NONE, '0);
					tok_state = PS_BEGIN_CMD;
				end else begin
					raise_error(clt_pkg::ERR_UNEXPECTED, c);
				end
			end
			PS_STRING: begin
				if (c == clt_pkg::CH_BSLASH) begin
					tok_state = PS_ESCAPE;
				end else if (c == clt_pkg::CH_QUOTE) begin
					tok_state = PS_BEGIN_ARG;
				end else if (text_ch(c)) begin
					add_event(clt_pkg::EV_APPEND, c, clt_pkg::ERR_NONE, '0);
				end else if (c == clt_pkg::CH_CR || c == clt_pkg::CH_LF) begin
					raise_error(clt_pkg::ERR_NEWLINE, c);
				end else begin
					raise_error(clt_pkg::ERR_UNEXPECTED, c);
				end
			end
			PS_IDENT: begin
				if (ident_ch(c)) begin
					add_event(clt_pkg::EV_APPEND, c, clt_pkg::ERR_NONE, '0);
				end else if (blank_ch(c)) begin
					tok_state = PS_BEGIN_ARG;
				end else if (delim_ch(c)) begin
					add_event(clt_pkg::EV_EXECUTE, 8'h00, clt_pkg::ERR_NONE, '0);
					tok_state = PS_BEGIN_CMD;
				end else begin
					raise_error(clt_pkg::ERR_UNEXPECTED, c);
				end
			end
			PS_ESCAPE: begin
				if (c == clt_pkg::CH_QUOTE || c == clt_pkg::CH_BSLASH) begin
					add_event(clt_pkg::EV_APPEND, c, clt_pkg::ERR_NONE, '0);
					tok_state = PS_STRING;
				end else begin
					raise_error(clt_pkg::ERR_ESCAPE, c);
				end
			end
			default: begin
				if (c == clt_pkg::CH_NUL) begin
					rearm();
				end
			end
		endcase
	endfunction

	// A held slash is released to the tokenizer ahead of the byte that follows it,
	// unless that byte is a second slash, which opens a comment.
	function automatic void predict_byte(logic [7:0] b);
		step_events.delete();
		if (tok_state == PS_DROP) begin
			if (b == clt_pkg::CH_NUL) begin
				rearm();
			end
			return;
		end
		if (slash_held) begin
			slash_held = 1'b0;
			if (b == clt_pkg::CH_SLASH) begin
				in_comment = 1'b1;
				return;
			end
			tokenize_char(clt_pkg::CH_SLASH);
		end
		if (b == clt_pkg::CH_NUL) begin
			tokenize_char(clt_pkg::CH_NUL);
		end else begin
			if (b == clt_pkg::CH_QUOTE) begin
				quoted = !quoted;
			end
			if (!quoted && !in_comment && b == clt_pkg::CH_SLASH) begin
				slash_held = 1'b1;
			end else begin
				if (b == clt_pkg::CH_LF) begin
					quoted     = 1'b0;
					in_comment = 1'b0;
				end
				if (!in_comment) begin
					tokenize_char(b);
				end
				if (b == clt_pkg::CH_LF && line_cnt != {clt_pkg::LINE_BITS{1'b1}}) begin
					line_cnt++;
				end
			end
		end
		if (step_events.size() > 0) begin
			step_events[step_events.size() - 1].last = 1'b1;
		end
	endfunction

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			text_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_bus.valid     <= 1'b1;
		text_bus.text_byte <= b;
		@(posedge clk);
		while (!text_bus.ready) @(posedge clk);
	endtask

	task automatic feed(input logic [7:0] b);
		send_byte(b);
		predict_byte(b);
		expected_events = {expected_events, step_events};
	endtask

	function automatic row_t plain(logic [7:0] b);
		row_t r;
		r   = '0;
		r.b = b;
		return r;
	endfunction

	function automatic row_t with_event(logic [7:0] b, clt_pkg::evkind_t k,
		clt_pkg::errcode_t code, logic [clt_pkg::LINE_BITS-1:0] ln);
		row_t r;
		r           = '0;
		r.b         = b;
		r.has_event = 1'b1;
		r.ev.kind   = k;
		r.ev.code   = code;
		r.ev.line   = ln;
		r.ev.last   = 1'b1;
		return r;
	endfunction

	function automatic logic [7:0] pick(string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	function automatic void put_byte(logic [7:0] c);
		text_q = {text_q, c};
	endfunction

	function automatic void add_ident(int n);
		repeat (n) put_byte(pick(IDENT_SET));
	endfunction

	function automatic void add_comment();
		put_byte(clt_pkg::CH_SLASH);
		put_byte(clt_pkg::CH_SLASH);
		repeat ($urandom_range(0, 5)) begin
			put_byte($urandom_range(0, 4) == 0 ? clt_pkg::CH_QUOTE : pick(BODY_SET));
		end
		put_byte(clt_pkg::CH_LF);
	endfunction

	function automatic void add_string();
		int r;
		put_byte(clt_pkg::CH_QUOTE);
		repeat ($urandom_range(0, 6)) begin
			r = $urandom_range(0, 29);
			if (r < 4) begin
				put_byte(clt_pkg::CH_BSLASH);
				put_byte($urandom_range(0, 1) ? clt_pkg::CH_QUOTE : clt_pkg::CH_BSLASH);
			end else if (r == 4) begin
				put_byte(clt_pkg::CH_BSLASH);
				put_byte(pick(IDENT_SET));
			end else if (r == 5) begin
				put_byte($urandom_range(0, 1) ? clt_pkg::CH_CR : clt_pkg::CH_LF);
			end else begin
				put_byte(pick(BODY_SET));
			end
		end
		put_byte(clt_pkg::CH_QUOTE);
	endfunction

	// Builds one text: one to four commands with random content, whose strings may hold
	// bad escapes or line breaks, a little byte noise on top, and a closing NUL.
	function automatic void build_text();
		text_q.delete();
		repeat ($urandom_range(1, 4)) begin
			repeat ($urandom_range(0, 2)) put_byte(pick(" \t\r\n"));
			if ($urandom_range(0, 7) == 0) begin
				add_comment();
			end
			add_ident($urandom_range(1, 5));
			repeat ($urandom_range(0, 3)) begin
				repeat ($urandom_range(1, 2)) put_byte(pick(" \t\r"));
				if ($urandom_range(0, 1)) begin
					add_ident($urandom_range(1, 4));
				end else begin
					add_string();
				end
			end
			if ($urandom_range(0, 5) == 0) begin
				put_byte(clt_pkg::CH_SPACE);
				add_comment();
			end else if ($urandom_range(0, 9) != 0) begin
				put_byte($urandom_range(0, 1) ? clt_pkg::CH_SEMI : clt_pkg::CH_LF);
			end
		end
		foreach (text_q[k]) begin
			if ($urandom_range(0, 29) == 0) begin
				text_q[k] = 8'($urandom_range(0, 255));
			end
		end
		put_byte(clt_pkg::CH_NUL);
	endfunction

	function automatic void check_event();
		clt_pkg::event_t e;
		events_seen++;
		if (expected_events.size() == 0) begin
			mismatches++;
			$error("unexpected event: event_kind %0d event_char %0d", ev_bus.event_kind,
				ev_bus.event_char);
			return;
		end
		e = expected_events.pop_front();
		if (ev_bus.event_kind !== e.kind) begin
			mismatches++;
			$error("event_kind: expected %0d, got %0d", e.kind, ev_bus.event_kind);
		end
		if (ev_bus.event_char !== e.ch) begin
			mismatches++;
			$error("event_char: expected %0d, got %0d", e.ch, ev_bus.event_char);
		end
		if (ev_bus.error_code !== e.code) begin
			mismatches++;
			$error("error_code: expected %0d, got %0d", e.code, ev_bus.error_code);
		end
		if (ev_bus.error_line !== e.line) begin
			mismatches++;
			$error("error_line: expected %0d, got %0d", e.line, ev_bus.error_line);
		end
		if (ev_bus.last !== e.last) begin
			mismatches++;
			$error("last: expected %0d, got %0d", e.last, ev_bus.last);
		end
	endfunction

	// The event sink stalls at random, runs stall-free for stretches, and once
	// holds off long enough for the block to back up onto its byte input.
	initial begin
		int stall_left;
		bit rx_fast;
		bit pressure_done;
		stall_left    = 0;
		rx_fast       = 1'b0;
		pressure_done = 1'b0;
		ev_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (ev_bus.valid === 1'b1 && ev_bus.ready === 1'b1) begin
				check_event();
			end
			if ($urandom_range(0, 149) == 0) begin
				rx_fast = !rx_fast;
			end
			if (!pressure_done && events_seen >= 150) begin
				pressure_done = 1'b1;
				stall_left    = 150;
			end
			if (stall_left > 0) begin
				stall_left--;
				ev_bus.ready <= 1'b0;
			end else if (!rx_fast && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap();
				ev_bus.ready <= 1'b0;
			end else begin
				ev_bus.ready <= 1'b1;
			end
		end
	end

	initial begin
		int random_sent;
		events_seen  = 0;
		mismatches   = 0;
		random_sent  = 0;
		tx_quiet     = 1'b0;
		arst_n       = 1'b0;
		text_bus.valid     <= 1'b0;
		text_bus.text_byte <= 8'h00;
		rearm();

		dir_rows = '{
			with_event(clt_pkg::CH_NUL, clt_pkg::EV_END, clt_pkg::ERR_NONE, '0),
			plain("a"), plain(clt_pkg::CH_SPACE), plain(clt_pkg::CH_QUOTE),
			plain(clt_pkg::CH_BSLASH), plain(clt_pkg::CH_QUOTE),
			plain(clt_pkg::CH_SLASH), plain("x"), plain(clt_pkg::CH_QUOTE), plain("9"),
			plain(clt_pkg::CH_LF),
			plain(clt_pkg::CH_SLASH), plain(clt_pkg::CH_SLASH), plain(clt_pkg::CH_QUOTE),
			plain("q"), plain(clt_pkg::CH_LF),
			with_event(8'hFF, clt_pkg::EV_ERROR, clt_pkg::ERR_UNEXPECTED,
				clt_pkg::LINE_BITS'(3)),
			plain(clt_pkg::CH_NUL),
			plain("b"), plain(clt_pkg::CH_SPACE), plain(clt_pkg::CH_QUOTE),
			with_event(clt_pkg::CH_LF, clt_pkg::EV_ERROR, clt_pkg::ERR_NEWLINE,
				clt_pkg::LINE_BITS'(1)),
			plain(clt_pkg::CH_NUL),
			plain("c"), plain(clt_pkg::CH_SPACE), plain(clt_pkg::CH_QUOTE),
			plain(clt_pkg::CH_BSLASH),
			with_event(clt_pkg::CH_NUL, clt_pkg::EV_ERROR, clt_pkg::ERR_ESCAPE,
				clt_pkg::LINE_BITS'(1))
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].has_event) begin
				send_byte(dir_rows[i].b);
				predict_byte(dir_rows[i].b);
				expected_events = {expected_events, dir_rows[i].ev};
			end else begin
				feed(dir_rows[i].b);
			end
		end

		while (random_sent < RANDOM_BYTES) begin
			build_text();
			tx_quiet = ($urandom_range(0, 3) == 0);
			foreach (text_q[k]) begin
				feed(text_q[k]);
			end
			random_sent += text_q.size();
		end

		tx_quiet = 1'b0;
		feed(8'hFF);
		feed(clt_pkg::CH_NUL);
		feed("z");
		feed(clt_pkg::CH_NUL);

		text_bus.valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatches == 0) begin
			$display("command_line_tokenizer_top regression: pass");
		end else begin
			$display("command_line_tokenizer_top regression: fail");
		end
		$finish;
	end

endmodule

[sim.f]
+incdir+design
design/clt_pkg.sv
design/clt_if.sv
design/clt_front.sv
design/clt_outq.sv
design/command_line_tokenizer_top.sv
tb/command_line_tokenizer_top_tb.sv
